// ----- rtl/hne_pkg.sv -----
// Shared types and constants for the heightmap normal engine.
// Used by hne_ctrl, hne_dp and heightmap_normal_engine; depends on nothing.
package hne_pkg;

    localparam int RD_TAPS    = 5;   // west, east, north, south, center
    localparam int SQ_STEPS   = 4;   // three squares plus one drain step
    localparam int SQRT_STEPS = 32;  // one result bit per step
    localparam int DIV_STEPS  = 15;  // quotient never exceeds 16384
    localparam int NUM_COMPS  = 3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_LOAD,
        OP_READ,
        OP_MUL,
        OP_SHIFT,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_STORE,
        OP_OUT
    } hne_op_t;

    typedef struct packed {
        hne_op_t    op;
        logic [4:0] step;
        logic [1:0] comp;
    } hne_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_query;
        logic out_free;
    } hne_stat_t;

endpackage

// ----- rtl/hne_ctrl.sv -----
// Sequencer for the heightmap normal engine: passes writes on from idle and walks one query through
// grid reads, slope products, square root and three divisions. Uses hne_pkg.
module hne_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  hne_pkg::hne_stat_t stat,
    output logic               in_ready,
    output hne_pkg::hne_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_MUL,
        S_SHIFT,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic [4:0] cnt_reg;
    logic [1:0] comp_reg;
    logic       in_ready_reg;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd.op   = hne_pkg::OP_NONE;
        cmd.step = cnt_reg;
        cmd.comp = comp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    cmd.op = stat.in_query ? hne_pkg::OP_LOAD : hne_pkg::OP_WRITE;
                end
            end
            S_READ:      cmd.op = hne_pkg::OP_READ;
            S_DRAIN:     cmd.op = hne_pkg::OP_NONE;
            S_MUL:       cmd.op = hne_pkg::OP_MUL;
            S_SHIFT:     cmd.op = hne_pkg::OP_SHIFT;
            S_SQ:        cmd.op = hne_pkg::OP_SQ;
            S_SQRT_INIT: cmd.op = hne_pkg::OP_SQRT_INIT;
            S_SQRT:      cmd.op = hne_pkg::OP_SQRT;
            S_DIV_INIT:  cmd.op = hne_pkg::OP_DIV_INIT;
            S_DIV:       cmd.op = hne_pkg::OP_DIV;
            S_DIV_STORE: cmd.op = hne_pkg::OP_DIV_STORE;
            S_DONE:      cmd.op = stat.out_free ? hne_pkg::OP_OUT : hne_pkg::OP_NONE;
            default:     cmd.op = hne_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            comp_reg     <= '0;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (stat.in_valid && stat.in_query)
                    begin
                        state_reg    <= S_READ;
                        cnt_reg      <= '0;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_READ:
                begin
                    if (cnt_reg == 5'(hne_pkg::RD_TAPS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_DRAIN: state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SHIFT;
                S_SHIFT:
                begin
                    state_reg <= S_SQ;
                    cnt_reg   <= '0;
                end
                S_SQ:
                begin
                    if (cnt_reg == 5'(hne_pkg::SQ_STEPS - 1))
                    begin
                        state_reg <= S_SQRT_INIT;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_SQRT_INIT:
                begin
                    state_reg <= S_SQRT;
                    cnt_reg   <= '0;
                end
                S_SQRT:
                begin
                    if (cnt_reg == 5'(hne_pkg::SQRT_STEPS - 1))
                    begin
                        state_reg <= S_DIV_INIT;
                        comp_reg  <= '0;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_DIV_INIT:
                begin
                    state_reg <= S_DIV;
                    cnt_reg   <= '0;
                end
                S_DIV:
                begin
                    if (cnt_reg == 5'(hne_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_DIV_STORE;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                S_DIV_STORE:
                begin
                    if (comp_reg == 2'(hne_pkg::NUM_COMPS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV_INIT;
                        comp_reg  <= comp_reg + 2'd1;
                    end
                end
                S_DONE:
                begin
                    if (stat.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/hne_dp.sv -----
// Datapath of the heightmap normal engine: height memory, slope products,
// sum of squares, bit-serial square root, shared divider, result register. Uses hne_pkg.
module hne_dp #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  hne_pkg::hne_cmd_t  cmd,
    input  logic [15:0]        spacing,
    input  logic signed [11:0] col,
    input  logic signed [11:0] row,
    input  logic [15:0]        height_in,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [15:0]        height_out,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [14:0]        normal_z,
    output logic               out_free
);

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [11:0] LAST_C = 12'(GRID_COLS - 1);
    localparam logic signed [11:0] LAST_R = 12'(GRID_ROWS - 1);
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    // height memory
    logic [15:0] mem [DEPTH];
    logic [15:0] mem_q;
    logic [AW-1:0] waddr, raddr;
    logic we, re;

    logic [CW-1:0] col_cl, col_reg, c_lo, c_hi, rd_c;
    logic [RW-1:0] row_cl, row_reg, r_lo, r_hi, rd_r;
    logic x_edge, y_edge;

    logic       pend_reg;
    logic [2:0] tap_reg;
    logic [15:0] h_reg [hne_pkg::RD_TAPS];

    logic [15:0] s_eff;
    logic [16:0] dx, dy;
    logic [15:0] da, db;
    logic        na, nb, na_reg, nb_reg;
    logic [32:0] ma_reg, mb_reg;
    logic [33:0] mc_reg, orv;
    logic [1:0]  sh;
    logic [30:0] a_reg, b_reg, c_reg, sq_op, mag;
    logic [61:0] prod_reg;
    logic [63:0] acc_reg, n_reg, r_reg, bit_reg, trial;
    logic [31:0] len;
    logic [46:0] num_reg, dsr_reg;
    logic [14:0] q_reg;
    logic [15:0] nx_reg, ny_reg;
    logic [14:0] nz_reg;

    logic        out_valid_reg;
    logic [15:0] height_out_reg, normal_x_reg, normal_y_reg;
    logic [14:0] normal_z_reg;

    // clamp query coordinates into the grid
    always_comb
    begin
        priority if (col < 0)       col_cl = '0;
        else if (col > LAST_C)      col_cl = CW'(GRID_COLS - 1);
        else                        col_cl = col[CW-1:0];
        priority if (row < 0)       row_cl = '0;
        else if (row > LAST_R)      row_cl = RW'(GRID_ROWS - 1);
        else                        row_cl = row[RW-1:0];
    end

    assign x_edge = (col_reg == '0) || (col_reg == CW'(GRID_COLS - 1));
    assign y_edge = (row_reg == '0) || (row_reg == RW'(GRID_ROWS - 1));
    assign c_lo = (col_reg == '0) ? col_reg : col_reg - CW'(1);
    assign c_hi = (col_reg == CW'(GRID_COLS - 1)) ? col_reg : col_reg + CW'(1);
    assign r_lo = (row_reg == '0) ? row_reg : row_reg - RW'(1);
    assign r_hi = (row_reg == RW'(GRID_ROWS - 1)) ? row_reg : row_reg + RW'(1);

    always_comb
    begin
        unique case (cmd.step[2:0])
            3'd0:    begin rd_c = c_lo;    rd_r = row_reg; end
            3'd1:    begin rd_c = c_hi;    rd_r = row_reg; end
            3'd2:    begin rd_c = col_reg; rd_r = r_lo;    end
            3'd3:    begin rd_c = col_reg; rd_r = r_hi;    end
            default: begin rd_c = col_reg; rd_r = row_reg; end
        endcase
    end

    assign raddr = AW'(rd_r) * AW'(GRID_COLS) + AW'(rd_c);
    assign waddr = AW'(row[RW-1:0]) * AW'(GRID_COLS) + AW'(col[CW-1:0]);
    assign re = (cmd.op == hne_pkg::OP_READ);
    assign we = (cmd.op == hne_pkg::OP_WRITE) && (col >= 0) && (col <= LAST_C)
                && (row >= 0) && (row <= LAST_R);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= height_in;
        end
        if (re)
        begin
            mem_q <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            tap_reg  <= '0;
        end
        else
        begin
            pend_reg <= re;
            tap_reg  <= cmd.step[2:0];
        end
    end

    // slopes and run lengths
    assign s_eff = (spacing == '0) ? 16'd1 : spacing;
    assign dx = x_edge ? {1'b0, s_eff} : {s_eff, 1'b0};
    assign dy = y_edge ? {1'b0, s_eff} : {s_eff, 1'b0};
    assign na = h_reg[1] > h_reg[0];
    assign nb = h_reg[3] > h_reg[2];
    assign da = na ? h_reg[1] - h_reg[0] : h_reg[0] - h_reg[1];
    assign db = nb ? h_reg[3] - h_reg[2] : h_reg[2] - h_reg[3];

    assign orv = {1'b0, ma_reg} | {1'b0, mb_reg} | mc_reg;
    always_comb
    begin
        priority if (orv[33]) sh = 2'd3;
        else if (orv[32])     sh = 2'd2;
        else if (orv[31])     sh = 2'd1;
        else                  sh = 2'd0;
    end

    always_comb
    begin
        unique case (cmd.step[1:0])
            2'd0:    sq_op = a_reg;
            2'd1:    sq_op = b_reg;
            2'd2:    sq_op = c_reg;
            default: sq_op = '0;
        endcase
        unique case (cmd.comp)
            2'd0:    mag = a_reg;
            2'd1:    mag = b_reg;
            default: mag = c_reg;
        endcase
    end

    assign trial = r_reg + bit_reg;
    assign len = (r_reg == '0) ? 32'd1 : r_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            h_reg[tap_reg] <= mem_q;
        end
        unique case (cmd.op)
            hne_pkg::OP_LOAD:
            begin
                col_reg <= col_cl;
                row_reg <= row_cl;
            end
            hne_pkg::OP_MUL:
            begin
                na_reg <= na;
                nb_reg <= nb;
                ma_reg <= 33'(da) * 33'(dy);
                mb_reg <= 33'(db) * 33'(dx);
                mc_reg <= 34'(dx) * 34'(dy);
            end
            hne_pkg::OP_SHIFT:
            begin
                a_reg <= 31'(ma_reg >> sh);
                b_reg <= 31'(mb_reg >> sh);
                c_reg <= 31'(mc_reg >> sh);
            end
            hne_pkg::OP_SQ:
            begin
                prod_reg <= sq_op * sq_op;
                acc_reg  <= (cmd.step[1:0] == 2'd0) ? 64'd0 : acc_reg + 64'(prod_reg);
            end
            hne_pkg::OP_SQRT_INIT:
            begin
                n_reg   <= acc_reg;
                r_reg   <= '0;
                bit_reg <= SQRT_BIT0;
            end
            hne_pkg::OP_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_reg <= n_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            hne_pkg::OP_DIV_INIT:
            begin
                num_reg <= 47'({mag, 14'b0}) + 47'(len[31:1]);
                dsr_reg <= 47'({len, 14'b0});
                q_reg   <= '0;
            end
            hne_pkg::OP_DIV:
            begin
                if (num_reg >= dsr_reg)
                begin
                    num_reg <= num_reg - dsr_reg;
                    q_reg   <= {q_reg[13:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[13:0], 1'b0};
                end
                dsr_reg <= dsr_reg >> 1;
            end
            hne_pkg::OP_DIV_STORE:
            begin
                unique case (cmd.comp)
                    2'd0:    nx_reg <= na_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
                    2'd1:    ny_reg <= nb_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
                    default: nz_reg <= q_reg;
                endcase
            end
            hne_pkg::OP_OUT:
            begin
                height_out_reg <= h_reg[4];
                normal_x_reg   <= nx_reg;
                normal_y_reg   <= ny_reg;
                normal_z_reg   <= nz_reg;
            end
            default:
            begin
            end
        endcase
    end

    // hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (cmd.op == hne_pkg::OP_OUT) out_valid_reg <= 1'b1;
            else if (out_ready)                     out_valid_reg <= 1'b0;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign height_out = height_out_reg;
    assign normal_x   = normal_x_reg;
    assign normal_y   = normal_y_reg;
    assign normal_z   = normal_z_reg;

endmodule

// ----- rtl/heightmap_normal_engine.sv -----
// Height grid with surface-normal query. A write (tuser 0) stores one height; a write outside
// the grid is dropped. A query (tuser 1) clamps column and row into the grid and returns the
// height there plus the unit normal in Q1.14. After a query, the earliest result transfer and
// the next input transfer can fall in the same cycle. A query takes five memory reads, a 32-step
// bit-serial square root and three 15-step divisions through one shared divider. One query
// is in flight at a time; the next item is taken once the result sits in the output register,
// so a result still waiting there holds off the end of the next query. Grid entries must be
// written before a query reads them. Depends on hne_pkg, hne_ctrl and hne_dp.
module heightmap_normal_engine #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // col[11:0], row[23:12], height_in[39:24]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // height_out[15:0], normal_x[31:16],
                                        // normal_y[47:32], normal_z[62:48], zero[63]
);

    localparam logic [1:0] REG_GRID_SPACING = 2'd0;

    logic [15:0]        grid_spacing_reg;
    hne_pkg::hne_cmd_t  cmd;
    hne_pkg::hne_stat_t stat;
    logic               in_ready, out_free;
    logic [15:0]        height_out;
    logic signed [15:0] normal_x, normal_y;
    logic [14:0]        normal_z;

    assign pready = 1'b1;
    assign prdata = {16'b0, grid_spacing_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_spacing_reg <= 16'd256;
        end
        else if (psel && penable && pwrite && (paddr == REG_GRID_SPACING))
        begin
            grid_spacing_reg <= pwdata[15:0];
        end
    end

    assign s_axis_tready = in_ready;
    assign stat.in_valid = s_axis_tvalid;
    assign stat.in_query = s_axis_tuser;
    assign stat.out_free = out_free;

    hne_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    hne_dp #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .spacing    (grid_spacing_reg),
        .col        (s_axis_tdata[11:0]),
        .row        (s_axis_tdata[23:12]),
        .height_in  (s_axis_tdata[39:24]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .height_out (height_out),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .out_free   (out_free)
    );

    assign m_axis_tdata = {1'b0, normal_z, normal_y, normal_x, height_out};

endmodule

// ----- tb/heightmap_normal_engine_tb.sv -----
// Self-checking testbench for heightmap_normal_engine: height writes and normal queries
// over the stream ports, spacing changes over APB, results checked against a local predictor.
// Depends on heightmap_normal_engine.
module heightmap_normal_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 64;
    localparam int ROWS = 64;
    localparam logic [1:0] REG_GRID_SPACING = 2'd0;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [15:0] height;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [14:0] nz;
    } surface_pt_t;

    class hne_scoreboard;
        logic [15:0] grid [COLS*ROWS];
        logic [15:0] spacing;
        surface_pt_t pending [$];
        int errors;

        function new();
            spacing = 16'd256;
            errors = 0;
            foreach (grid[i]) grid[i] = '0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic [15:0] to_unit(longint unsigned mag, bit neg, longint unsigned len);
            longint unsigned q;
            q = (mag * 16384 + len / 2) / len;
            if (neg) q = -q;
            return q[15:0];
        endfunction

        // Note an accepted input transfer; a query queues its expected surface point.
        function void note_item(logic cmd, int c, int r, logic [15:0] h);
            longint unsigned s, dx, dy, ma, mb, mc, big, len;
            int cl, ch, rl, rh;
            int hl, hh;
            bit na, nb;
            surface_pt_t pt;
            if (cmd == CMD_WRITE)
            begin
                if (c >= 0 && c < COLS && r >= 0 && r < ROWS) grid[r*COLS + c] = h;
                return;
            end
            c = (c < 0) ? 0 : (c >= COLS) ? COLS - 1 : c;
            r = (r < 0) ? 0 : (r >= ROWS) ? ROWS - 1 : r;
            s = (spacing == 0) ? 1 : spacing;
            cl = (c == 0) ? 0 : c - 1;
            ch = (c == COLS - 1) ? c : c + 1;
            rl = (r == 0) ? 0 : r - 1;
            rh = (r == ROWS - 1) ? r : r + 1;
            dx = ((c == 0 || c == COLS - 1) ? 1 : 2) * s;
            dy = ((r == 0 || r == ROWS - 1) ? 1 : 2) * s;
            hl = grid[r*COLS + cl];
            hh = grid[r*COLS + ch];
            na = hh > hl;
            ma = longint'(na ? hh - hl : hl - hh) * dy;
            hl = grid[rl*COLS + c];
            hh = grid[rh*COLS + c];
            nb = hh > hl;
            mb = longint'(nb ? hh - hl : hl - hh) * dx;
            mc = dx * dy;
            big = ma;
            if (mb > big) big = mb;
            if (mc > big) big = mc;
            // scale all three together until they fit in 31 bits
            while (big >= (64'd1 << 31))
            begin
                ma = ma >> 1;
                mb = mb >> 1;
                mc = mc >> 1;
                big = big >> 1;
            end
            len = int_sqrt(ma*ma + mb*mb + mc*mc);
            if (len == 0) len = 1;
            pt.height = grid[r*COLS + c];
            pt.nx = to_unit(ma, na, len);
            pt.ny = to_unit(mb, nb, len);
            pt.nz = 15'(to_unit(mc, 1'b0, len));
            pending.push_back(pt);
        endfunction

        function void check_result(logic [63:0] d);
            surface_pt_t pt;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer %h", d);
                return;
            end
            pt = pending.pop_front();
            if (d[15:0] !== pt.height || d[31:16] !== pt.nx || d[47:32] !== pt.ny ||
                d[62:48] !== pt.nz || d[63] !== 1'b0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp h=%h nx=%h ny=%h nz=%h, got h=%h nx=%h ny=%h nz=%h",
                             pt.height, pt.nx, pt.ny, pt.nz,
                             d[15:0], d[31:16], d[47:32], d[62:48]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // col[11:0], row[23:12], height_in[39:24]
    logic        s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // height_out, normal_x, normal_y, normal_z, zero

    hne_scoreboard sb;
    bit written [COLS*ROWS];
    int snd_idle;
    int rcv_idle;
    int sent_items;

    heightmap_normal_engine DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("heightmap_normal_engine_tb: done, errors");
        $finish;
    end

    always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rcv_idle);

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    task automatic send_item(logic cmd, logic [11:0] c, logic [11:0] r, logic [15:0] h);
        int gap;
        if ($urandom_range(99) < snd_idle)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {h, r, c};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(cmd, int'($signed(c)), int'($signed(r)), h);
        sent_items++;
        if (cmd == CMD_WRITE && $signed(c) >= 0 && $signed(c) < COLS &&
            $signed(r) >= 0 && $signed(r) < ROWS)
            written[int'($signed(r))*COLS + int'($signed(c))] = 1'b1;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 40'({$urandom, $urandom});
        s_axis_tuser = 1'($urandom);
    endtask

    task automatic fill_if_blank(int c, int r);
        if (!written[r*COLS + c]) send_item(CMD_WRITE, 12'(c), 12'(r), 16'($urandom));
    endtask

    // Make sure every tap of the clamped point holds data, then issue the query.
    task automatic send_query(logic [11:0] c, logic [11:0] r);
        int cc, rr;
        cc = int'($signed(c));
        rr = int'($signed(r));
        cc = (cc < 0) ? 0 : (cc >= COLS) ? COLS - 1 : cc;
        rr = (rr < 0) ? 0 : (rr >= ROWS) ? ROWS - 1 : rr;
        fill_if_blank(cc, rr);
        fill_if_blank((cc == 0) ? 0 : cc - 1, rr);
        fill_if_blank((cc == COLS - 1) ? cc : cc + 1, rr);
        fill_if_blank(cc, (rr == 0) ? 0 : rr - 1);
        fill_if_blank(cc, (rr == ROWS - 1) ? rr : rr + 1);
        send_item(CMD_QUERY, c, r, 16'($urandom));
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == REG_GRID_SPACING) sb.spacing = data[15:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Send about n input transfers, fill writes included.
    task automatic random_items(int n);
        logic [11:0] c, r;
        int stop;
        stop = sent_items + n;
        while (sent_items < stop)
        begin
            if ($urandom_range(99) < 75)
            begin
                c = 12'($urandom_range(COLS - 1));
                r = 12'($urandom_range(ROWS - 1));
            end
            else
            begin
                c = 12'($urandom);
                r = 12'($urandom);
            end
            if ($urandom_range(99) < 35) send_item(CMD_WRITE, c, r, 16'($urandom));
            else send_query(c, r);
        end
    endtask

    initial
    begin
        logic [15:0] spacings [5];
        sb = new();
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_WRITE;
        m_axis_tready = 1'b0;
        snd_idle = 0;
        rcv_idle = 0;
        sent_items = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // writes outside the grid are dropped
        send_item(CMD_WRITE, -12'sd2048, -12'sd2048, 16'hFFFF);
        send_item(CMD_WRITE, 12'sd2047, 12'sd2047, 16'hFFFF);
        send_item(CMD_WRITE, 12'd64, 12'd0, 16'hFFFF);
        send_item(CMD_WRITE, 12'd0, 12'd64, 16'hFFFF);
        send_item(CMD_WRITE, -12'sd1, 12'd5, 16'hFFFF);
        // interior point with randomly filled taps at reset spacing
        send_query(12'd31, 12'd31);
        // cliff at the corner: very steep slope
        send_item(CMD_WRITE, 12'd0, 12'd0, 16'h0000);
        send_item(CMD_WRITE, 12'd1, 12'd0, 16'hFFFF);
        send_item(CMD_WRITE, 12'd0, 12'd1, 16'h0000);
        send_query(12'd0, 12'd0);
        send_query(12'd63, 12'd63);
        send_query(-12'sd2048, 12'sd2047);
        send_query(12'sd2047, -12'sd2048);
        send_query(12'd100, 12'd30);
        drain();
        // tiny spacing: normal_z rounds to zero on the cliff
        apb_write(REG_GRID_SPACING, 32'd1);
        send_query(12'd0, 12'd0);
        send_query(12'd1, 12'd0);
        send_query(12'd30, -12'sd5);
        drain();

        spacings[0] = 16'hFFFF;
        spacings[1] = 16'h0000;
        spacings[2] = 16'd256;
        spacings[3] = 16'($urandom);
        spacings[4] = 16'($urandom_range(1, 16));
        for (int ph = 0; ph < 5; ph++)
        begin
            apb_write(REG_GRID_SPACING, {16'h0, spacings[ph]});
            if (ph < 2)
            begin
                snd_idle = 6;
                rcv_idle = 45;
            end
            else if (ph < 4)
            begin
                snd_idle = 45;
                rcv_idle = 6;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            random_items(166);
            drain();
        end

        if (sb.errors == 0)
            $display("heightmap_normal_engine_tb: done, clean");
        else
            $display("heightmap_normal_engine_tb: done, errors");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/hne_pkg.sv
rtl/hne_ctrl.sv
rtl/hne_dp.sv
rtl/heightmap_normal_engine.sv
tb/heightmap_normal_engine_tb.sv
